// ===== rtl/hmc_pkg.sv =====
// ----------------------------------------------------------------------------
// hmc_pkg
// Shared types, codes and constants of the hypothesis match classifier.
// ----------------------------------------------------------------------------
package hmc_pkg;

    // Default sizing of the hypothesis tables.
    localparam int DEF_HYP_DEPTH  = 256;
    localparam int DEF_ATTR_WIDTH = 64;

    // Fixed field widths of the command and result ports.
    localparam int OPCODE_W = 2;
    localparam int OBJ_W    = 64;
    localparam int VERDICT_W = 2;
    localparam int COUNT_W  = 9;
    localparam int SHARE_W  = 17;

    // Vote share is Q1.16; one fraction bit is produced per division step.
    localparam int SHARE_FRAC_W = 16;
    localparam logic [SHARE_W-1:0] SHARE_HALF = 17'd32768;
    localparam logic [SHARE_W-1:0] SHARE_ONE  = 17'd65536;

    // Command opcodes.
    localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_POS = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOAD_NEG = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLASSIFY = 2'd3;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] V_NEGATIVE      = 2'd0;
    localparam logic [VERDICT_W-1:0] V_POSITIVE      = 2'd1;
    localparam logic [VERDICT_W-1:0] V_CONTRADICTORY = 2'd2;
    localparam logic [VERDICT_W-1:0] V_UNDETERMINED  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load_pos;
        logic load_neg;
        logic scan_init;
        logic scan_run;
        logic div_init;
        logic div_run;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic scan_done;
        logic div_done;
    } t_dp_status;

endpackage

// ===== rtl/hmc_controller.sv =====
// ----------------------------------------------------------------------------
// hmc_controller
// Sequencer that decodes each command and steps classify commands through table scan and share division.
// ----------------------------------------------------------------------------
module hmc_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [hmc_pkg::OPCODE_W-1:0]     i_opcode,
    input  hmc_pkg::t_dp_status              i_dp_st,
    output logic                             o_busy,
    output hmc_pkg::t_dp_cmd                 o_cmd
);
    import hmc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        OP_CLEAR:    o_cmd.clear    = 1'b1;
                        OP_LOAD_POS: o_cmd.load_pos = 1'b1;
                        OP_LOAD_NEG: o_cmd.load_neg = 1'b1;
                        default: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_dp_st.scan_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                if (i_dp_st.div_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.div_run = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/hmc_datapath.sv =====
// ----------------------------------------------------------------------------
// hmc_datapath
// Hypothesis tables, match counters, serial share divider and result registers.
// ----------------------------------------------------------------------------
module hmc_datapath #(
    parameter int HYP_DEPTH  = hmc_pkg::DEF_HYP_DEPTH,
    parameter int ATTR_WIDTH = hmc_pkg::DEF_ATTR_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hmc_pkg::t_dp_cmd                  i_cmd,
    input  logic [hmc_pkg::OBJ_W-1:0]         i_attrs,
    input  logic [hmc_pkg::OBJ_W-1:0]         i_attrs_reversed,
    output hmc_pkg::t_dp_status               o_dp_st,
    output logic                              o_strobe,
    output logic                              o_status,
    output logic [hmc_pkg::VERDICT_W-1:0]     o_verdict,
    output logic [hmc_pkg::COUNT_W-1:0]       o_positive_matches,
    output logic [hmc_pkg::COUNT_W-1:0]       o_negative_matches,
    output logic [hmc_pkg::SHARE_W-1:0]       o_vote_share
);
    import hmc_pkg::*;

    localparam int AW = (HYP_DEPTH > 1) ? $clog2(HYP_DEPTH) : 1;
    localparam int CW = $clog2(HYP_DEPTH + 1);
    localparam int RW = CW + 1;
    localparam int SW = $clog2(SHARE_FRAC_W + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HYP_DEPTH);

    logic [ATTR_WIDTH-1:0] r_pos_mem [HYP_DEPTH];
    logic [ATTR_WIDTH-1:0] r_neg_mem [HYP_DEPTH];

    logic [CW-1:0]         r_pos_used;
    logic [CW-1:0]         r_neg_used;
    logic [ATTR_WIDTH-1:0] r_obj;
    logic [ATTR_WIDTH-1:0] r_obj_rev;
    logic [CW-1:0]         r_addr;
    logic                  r_pv;
    logic                  r_nv;
    logic [ATTR_WIDTH-1:0] r_pdata;
    logic [ATTR_WIDTH-1:0] r_ndata;
    logic [CW-1:0]         r_pcnt;
    logic [CW-1:0]         r_ncnt;
    logic [RW-1:0]         r_rem;
    logic [RW-1:0]         r_div;
    logic [SHARE_W-1:0]    r_quo;
    logic [SW-1:0]         r_dcnt;

    logic                  r_strobe;
    logic                  r_stat;
    logic [VERDICT_W-1:0]  r_verdict;
    logic [COUNT_W-1:0]    r_pm;
    logic [COUNT_W-1:0]    r_nm;
    logic [SHARE_W-1:0]    r_share;

    logic                  pos_full;
    logic                  neg_full;
    logic [CW-1:0]         scan_limit;
    logic                  scan_issue;
    logic                  pos_hit;
    logic                  neg_hit;
    logic [RW-1:0]         count_sum;
    logic [RW:0]           rem_sh;
    logic                  sub_ok;
    logic [RW:0]           rem_diff;
    logic [RW-1:0]         n_rem;
    logic [VERDICT_W-1:0]  n_verdict;

    assign pos_full   = (r_pos_used == DEPTH_C);
    assign neg_full   = (r_neg_used == DEPTH_C);
    assign scan_limit = (r_pos_used > r_neg_used) ? r_pos_used : r_neg_used;
    assign scan_issue = i_cmd.scan_run && (r_addr < scan_limit);

    // A hypothesis matches when none of its bits is missing from the object (the reversed object for negative ones).
    assign pos_hit = r_pv && ((r_pdata & ~r_obj) == '0);
    assign neg_hit = r_nv && ((r_ndata & ~r_obj_rev) == '0);

    assign count_sum = {1'b0, r_pcnt} + {1'b0, r_ncnt};

    // Restoring division step; the remainder stays below the divisor while the division runs.
    assign rem_sh   = {r_rem, 1'b0};
    assign sub_ok   = (rem_sh >= {1'b0, r_div});
    assign rem_diff = rem_sh - {1'b0, r_div};
    assign n_rem    = sub_ok ? rem_diff[RW-1:0] : rem_sh[RW-1:0];

    always_comb begin
        if ((r_pcnt != '0) && (r_ncnt != '0)) begin
            n_verdict = V_CONTRADICTORY;
        end else if (r_pcnt != '0) begin
            n_verdict = V_POSITIVE;
        end else if (r_ncnt != '0) begin
            n_verdict = V_NEGATIVE;
        end else begin
            n_verdict = V_UNDETERMINED;
        end
    end

    assign o_dp_st.scan_done = (r_addr >= scan_limit) && !r_pv && !r_nv;
    assign o_dp_st.div_done  = (r_dcnt == '0);

    // Table storage: one write port for loads, one registered read for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pos && !pos_full) begin
            r_pos_mem[r_pos_used[AW-1:0]] <= i_attrs[ATTR_WIDTH-1:0];
        end
        if (scan_issue) begin
            r_pdata <= r_pos_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_neg && !neg_full) begin
            r_neg_mem[r_neg_used[AW-1:0]] <= i_attrs[ATTR_WIDTH-1:0];
        end
        if (scan_issue) begin
            r_ndata <= r_neg_mem[r_addr[AW-1:0]];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_used <= '0;
            r_neg_used <= '0;
            r_addr     <= '0;
            r_pv       <= 1'b0;
            r_nv       <= 1'b0;
            r_dcnt     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= i_cmd.clear || i_cmd.load_pos || i_cmd.load_neg || i_cmd.finish;
            if (i_cmd.clear) begin
                r_pos_used <= '0;
                r_neg_used <= '0;
            end
            if (i_cmd.load_pos && !pos_full) begin
                r_pos_used <= r_pos_used + 1'b1;
            end
            if (i_cmd.load_neg && !neg_full) begin
                r_neg_used <= r_neg_used + 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_addr <= '0;
                r_pv   <= 1'b0;
                r_nv   <= 1'b0;
            end else if (scan_issue) begin
                r_addr <= r_addr + 1'b1;
                r_pv   <= (r_addr < r_pos_used);
                r_nv   <= (r_addr < r_neg_used);
            end else begin
                r_pv <= 1'b0;
                r_nv <= 1'b0;
            end
            if (i_cmd.div_init) begin
                if ((r_pcnt == r_ncnt) || (r_ncnt == '0)) begin
                    r_dcnt <= '0;
                end else begin
                    r_dcnt <= SW'(SHARE_FRAC_W);
                end
            end else if (i_cmd.div_run && (r_dcnt != '0)) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
        end
    end

    // Payload: object, counters, divider and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_obj     <= i_attrs[ATTR_WIDTH-1:0];
            r_obj_rev <= i_attrs_reversed[ATTR_WIDTH-1:0];
            r_pcnt    <= '0;
            r_ncnt    <= '0;
        end else begin
            if (pos_hit) begin
                r_pcnt <= r_pcnt + 1'b1;
            end
            if (neg_hit) begin
                r_ncnt <= r_ncnt + 1'b1;
            end
        end

        if (i_cmd.div_init) begin
            r_rem <= {1'b0, r_pcnt};
            r_div <= count_sum;
            if (r_pcnt == r_ncnt) begin
                r_quo <= SHARE_HALF;
            end else if (r_ncnt == '0) begin
                r_quo <= SHARE_ONE;
            end else begin
                r_quo <= '0;
            end
        end else if (i_cmd.div_run && (r_dcnt != '0)) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SHARE_W-2:0], sub_ok};
        end

        if (i_cmd.finish) begin
            r_stat    <= 1'b0;
            r_verdict <= n_verdict;
            r_pm      <= COUNT_W'(r_pcnt);
            r_nm      <= COUNT_W'(r_ncnt);
            r_share   <= r_quo;
        end else if (i_cmd.clear || i_cmd.load_pos || i_cmd.load_neg) begin
            r_stat    <= (i_cmd.load_pos && pos_full) || (i_cmd.load_neg && neg_full);
            r_verdict <= V_NEGATIVE;
            r_pm      <= '0;
            r_nm      <= '0;
            r_share   <= '0;
        end
    end

    assign o_strobe           = r_strobe;
    assign o_status           = r_stat;
    assign o_verdict          = r_verdict;
    assign o_positive_matches = r_pm;
    assign o_negative_matches = r_nm;
    assign o_vote_share       = r_share;

`ifndef NO_ASSERTIONS
    a_used_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos_used <= DEPTH_C) && (r_neg_used <= DEPTH_C))
        else $error("table fill count beyond table depth");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dcnt != '0) |-> (r_rem < r_div))
        else $error("division remainder not below divisor");

    a_share_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_share <= SHARE_ONE))
        else $error("vote share above one");

    a_undet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_verdict == V_UNDETERMINED)) |-> ((r_pm == '0) && (r_nm == '0)))
        else $error("undetermined verdict with nonzero match count");
`endif

endmodule

// ===== rtl/hypothesis_match_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// hypothesis_match_classifier_unit
// Classifies objects against loaded positive and negative hypothesis tables.
// ----------------------------------------------------------------------------
// A command beat is taken at a rising edge where start is high and busy is
// low; i_opcode selects clear, load positive, load negative or classify.
// Every command produces exactly one result beat, shown for one cycle with
// o_strobe high. The receiver cannot stall, so results are never held back.
// Clear and load commands finish in one cycle: the result appears in the
// cycle after the command, and busy stays low so a new command may follow
// back to back. A load into a full table is dropped and reports o_status 1.
// Classify scans both tables in parallel, one entry of each per cycle from a
// registered memory read, then runs a 16-step restoring division for the
// vote share unless the counts fix it at one half or one. The table scan
// dominates its run time, which grows with max(positive used, negative
// used). Reset empties both tables (their contents are simply forgotten)
// and returns the sequencer to idle with no result pending.
// ----------------------------------------------------------------------------
module hypothesis_match_classifier_unit #(
    parameter int HYP_DEPTH  = hmc_pkg::DEF_HYP_DEPTH,
    parameter int ATTR_WIDTH = hmc_pkg::DEF_ATTR_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [hmc_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [hmc_pkg::OBJ_W-1:0]         i_attrs,
    input  logic [hmc_pkg::OBJ_W-1:0]         i_attrs_reversed,
    output logic                              o_strobe,
    output logic                              o_status,
    output logic [hmc_pkg::VERDICT_W-1:0]     o_verdict,
    output logic [hmc_pkg::COUNT_W-1:0]       o_positive_matches,
    output logic [hmc_pkg::COUNT_W-1:0]       o_negative_matches,
    output logic [hmc_pkg::SHARE_W-1:0]       o_vote_share
);
    import hmc_pkg::*;

    // The controller and datapath talk only through these two bundles.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_st;

    // The sequencer decodes each accepted beat and walks classify commands
    // through the scan and division phases.
    hmc_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_dp_st  (dp_st),
        .o_busy   (busy),
        .o_cmd    (dp_cmd)
    );

    // The datapath owns both tables, the match counters, the divider and
    // the registered result fields.
    hmc_datapath #(
        .HYP_DEPTH  (HYP_DEPTH),
        .ATTR_WIDTH (ATTR_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_attrs            (i_attrs),
        .i_attrs_reversed   (i_attrs_reversed),
        .o_dp_st            (dp_st),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_verdict          (o_verdict),
        .o_positive_matches (o_positive_matches),
        .o_negative_matches (o_negative_matches),
        .o_vote_share       (o_vote_share)
    );

endmodule
